// ===== hdl/multi_list_append_buffer_top_macros.svh =====
// Assertion macros used by the multi-list append buffer datapath module.
`ifndef MULTI_LIST_APPEND_BUFFER_TOP_MACROS_SVH
`define MULTI_LIST_APPEND_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLAB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mlab assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MLAB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mlab assertion failed");

`endif

// ===== hdl/mlab_pkg.sv =====
// Types and codes shared by the multi-list append buffer modules.
package mlab_pkg;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_DUMP  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] KIND_ELEMENT = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_REJECT  = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [3:0]         list_index;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] element;
		logic [1:0]         result_kind;
		logic               last_of_run;
	} rsp_t;

	typedef struct packed {
		logic push_wr;
		logic clr;
		logic mark_start;
		logic dump_start;
		logic mark_emit;
		logic dump_emit;
	} cmd_t;

	typedef struct packed {
		logic is_push;
		logic is_dump;
		logic is_clear;
		logic full;
		logic empty;
		logic out_free;
		logic dump_last;
	} stat_t;

endpackage

// ===== hdl/mlab_ctrl.sv =====
// Controller state machine: accepts transactions and sequences markers and dumps.
module mlab_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  mlab_pkg::stat_t      stat,
	output mlab_pkg::cmd_t       cmd
);
	import mlab_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MARK = 3'b010,
		ST_DUMP = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   acc;

	assign req_stall = (state_q != ST_IDLE);
	assign acc       = req_valid && (state_q == ST_IDLE);

	always_comb begin
		cmd.push_wr    = acc && stat.is_push && !stat.full;
		cmd.clr        = acc && stat.is_clear;
		cmd.mark_start = acc && ((stat.is_push && stat.full) || (stat.is_dump && stat.empty));
		cmd.dump_start = acc && stat.is_dump && !stat.empty;
		cmd.mark_emit  = (state_q == ST_MARK) && stat.out_free;
		cmd.dump_emit  = (state_q == ST_DUMP) && stat.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.mark_start) begin
					state_d = ST_MARK;
				end else if (cmd.dump_start) begin
					state_d = ST_DUMP;
				end
			end
			ST_MARK: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DUMP: begin
				if (stat.out_free && stat.dump_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/mlab_dp.sv =====
// Datapath: fill counts, partitioned element store, dump pointers and result register.
`include "multi_list_append_buffer_top_macros.svh"

module mlab_dp #(
	parameter int NUM_LISTS  = 16,
	parameter int LIST_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mlab_pkg::req_t       req,
	input  logic                 rsp_stall,
	output logic                 rsp_valid,
	output mlab_pkg::rsp_t       rsp,
	input  mlab_pkg::cmd_t       cmd,
	output mlab_pkg::stat_t      stat
);
	import mlab_pkg::*;

	localparam int LIST_W    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int PW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW        = $clog2(LIST_DEPTH + 1);
	localparam int AW        = LIST_W + PW;
	localparam int MEM_DEPTH = NUM_LISTS * (2 ** PW);

	logic [CW-1:0]     cnt_q [NUM_LISTS];
	logic [31:0]       mem [MEM_DEPTH];
	logic [31:0]       rd_data_q;
	logic [LIST_W-1:0] lidx;
	logic              in_range;
	logic [CW-1:0]     cur_cnt;
	logic [LIST_W-1:0] dlist_q;
	logic [CW-1:0]     dcnt_q;
	logic [CW-1:0]     dpos_q;
	logic [CW-1:0]     nxt_pos;
	logic [1:0]        kind_q;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic              out_free;

	assign lidx     = LIST_W'(req.list_index);
	assign in_range = int'(req.list_index) < NUM_LISTS;
	assign cur_cnt  = in_range ? cnt_q[lidx] : '0;
	assign nxt_pos  = dpos_q + CW'(1);
	assign out_free = !rsp_valid || !rsp_stall;

	always_comb begin
		stat.is_push   = in_range && (req.operation == OP_PUSH);
		stat.is_dump   = in_range && (req.operation == OP_DUMP);
		stat.is_clear  = in_range && (req.operation == OP_CLEAR);
		stat.full      = cur_cnt >= CW'(LIST_DEPTH);
		stat.empty     = (cur_cnt == '0);
		stat.out_free  = out_free;
		stat.dump_last = (nxt_pos == dcnt_q);
	end

	// fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LISTS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.push_wr) begin
			cnt_q[lidx] <= cur_cnt + CW'(1);
		end else if (cmd.clr) begin
			cnt_q[lidx] <= '0;
		end
	end

	// element store, one write and one registered read port
	assign wr_addr = {lidx, cur_cnt[PW-1:0]};
	assign rd_en   = cmd.dump_start || (cmd.dump_emit && !stat.dump_last);
	assign rd_addr = cmd.dump_start ? {lidx, PW'(0)} : {dlist_q, nxt_pos[PW-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.push_wr) begin
			mem[wr_addr] <= req.push_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// dump pointers and pending marker kind
	always_ff @(posedge clk) begin
		if (cmd.dump_start) begin
			dlist_q <= lidx;
			dcnt_q  <= cur_cnt;
			dpos_q  <= '0;
		end else if (cmd.dump_emit) begin
			dpos_q  <= nxt_pos;
		end
		if (cmd.mark_start) begin
			kind_q <= stat.is_push ? KIND_REJECT : KIND_EMPTY;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.dump_emit || cmd.mark_emit) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dump_emit) begin
			rsp.element     <= rd_data_q;
			rsp.result_kind <= KIND_ELEMENT;
			rsp.last_of_run <= stat.dump_last;
		end else if (cmd.mark_emit) begin
			rsp.element     <= '0;
			rsp.result_kind <= kind_q;
			rsp.last_of_run <= 1'b1;
		end
	end

	`MLAB_ASSERT_IMP(a_cmd_excl, clk, arst_n, 1'b1, $onehot0(cmd))
	`MLAB_ASSERT_IMP(a_push_room, clk, arst_n, cmd.push_wr, cur_cnt < CW'(LIST_DEPTH))
	`MLAB_ASSERT_IMP(a_dump_bound, clk, arst_n, cmd.dump_emit, dpos_q < dcnt_q)

endmodule

// ===== hdl/multi_list_append_buffer_top.sv =====
// Multi-list append buffer: NUM_LISTS append-only lists of LIST_DEPTH signed
// words each, with push, dump and clear. Push and clear complete on acceptance
// and the block stays ready for the next request. A rejected push or a dump
// of an empty list runs acceptance, then loading the marker into the result
// register. A dump of a list holding N elements issues the first read of the
// element store at acceptance, then moves one element per cycle into the result
// register while the result side does not stall. Requests are stalled until the
// last result of a marker or dump is in the result register. Fill counts sit in
// registers cleared by reset, so no clearing pass runs after reset. A list_index
// at or above NUM_LISTS and operation code 3 are taken and ignored.
module multi_list_append_buffer_top #(
	parameter int NUM_LISTS  = 16,
	parameter int LIST_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  mlab_pkg::req_t       req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output mlab_pkg::rsp_t       rsp
);
	import mlab_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mlab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mlab_dp #(
		.NUM_LISTS  (NUM_LISTS),
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
